// File: hdl/iss_pkg.sv
// iss_pkg: shared types and constants for the indirect selection sorter
// used by indirect_selection_sort and iss_min_track, no dependencies
`timescale 1ns / 1ps
`default_nettype none

package iss_pkg;

  localparam int MAX_ITEMS_DEF = 64;
  localparam int VALUE_W       = 32;
  localparam int INDEX_W       = 6;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] sorted_value;
    logic [INDEX_W-1:0]        source_index;
    logic                      end_of_run;
    logic                      overflow;
  } out_item_t;

  // one read beat of the scan, aligned with the registered memory data
  typedef struct packed {
    logic               vld;
    logic               first;
    logic [INDEX_W-1:0] pos;
  } scan_beat_t;

endpackage

`default_nettype wire

// File: hdl/iss_min_track.sv
// iss_min_track: running minimum over one selection pass of the sorter
// depends on iss_pkg for the scan beat type and value width
`timescale 1ns / 1ps
`default_nettype none

module iss_min_track #(
  parameter int AW = 6
) (
  input  wire logic                              clk,
  input  wire iss_pkg::scan_beat_t               beat,
  input  wire logic [iss_pkg::VALUE_W+AW-1:0]    rdata,
  output logic      [iss_pkg::VALUE_W+AW-1:0]    min_entry,
  output logic      [AW-1:0]                     min_pos,
  output logic      [iss_pkg::VALUE_W+AW-1:0]    first_entry
);

  localparam int EW = iss_pkg::VALUE_W + AW;

  logic less;

  // strictly smaller only, so the first of equal minima is kept
  assign less = $signed(rdata[EW-1 -: iss_pkg::VALUE_W])
              < $signed(min_entry[EW-1 -: iss_pkg::VALUE_W]);

  always_ff @(posedge clk) begin
    if (beat.vld) begin
      if (beat.first || less) begin
        min_entry <= rdata;
        min_pos   <= beat.pos[AW-1:0];
      end
      if (beat.first) begin
        first_entry <= rdata;
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/indirect_selection_sort.sv
// indirect_selection_sort: collects signed values, sorts them by selection sort
// in one (value, arrival index) memory, then emits them in ascending order.
// items are accepted only while loading; each pass of the sort scans the unsorted
// tail (one read per cycle on the single read port), drains, then does two swap
// writes; each result is read once the output register is free, then loaded into it.
// synchronous reset clears control state; memory contents are kept.
`timescale 1ns / 1ps
`default_nettype none

module indirect_selection_sort #(
  parameter int MAX_ITEMS = iss_pkg::MAX_ITEMS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire iss_pkg::in_item_t    item,
  input  wire logic                 item_valid,
  output logic                      item_stall,
  output iss_pkg::out_item_t        result,
  output logic                      result_valid,
  input  wire logic                 result_stall
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int EW = iss_pkg::VALUE_W + AW;

  localparam logic [2:0] ST_LOAD    = 3'd0;
  localparam logic [2:0] ST_SCAN    = 3'd1;
  localparam logic [2:0] ST_DRAIN   = 3'd2;
  localparam logic [2:0] ST_SWAP_A  = 3'd3;
  localparam logic [2:0] ST_SWAP_B  = 3'd4;
  localparam logic [2:0] ST_EMIT_RD = 3'd5;
  localparam logic [2:0] ST_EMIT_LD = 3'd6;

  logic [2:0]    state;
  logic [CW-1:0] count;
  logic          ovf;
  logic [AW-1:0] last_pos;
  logic [AW-1:0] pass;
  logic [AW-1:0] addr;

  logic [EW-1:0] mem [MAX_ITEMS];
  logic [EW-1:0] rdata;
  logic          wen;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata;

  iss_pkg::scan_beat_t beat;
  logic [EW-1:0] min_entry;
  logic [AW-1:0] min_pos;
  logic [EW-1:0] first_entry;

  logic          item_acc;
  logic          full;
  logic [AW-1:0] last_pos_next;
  logic [AW-1:0] pass_inc;

  assign item_stall    = rst || (state != ST_LOAD);
  assign item_acc      = item_valid && !item_stall;
  assign full          = (count == CW'(MAX_ITEMS));
  // a dropped item still closes the set with the values already stored
  assign last_pos_next = full ? AW'(count - 1'b1) : AW'(count);
  assign pass_inc      = pass + 1'b1;

  always_comb begin
    wen   = 1'b0;
    waddr = addr;
    wdata = first_entry;
    case (state)
      ST_LOAD: begin
        wen   = item_acc && !full;
        waddr = AW'(count);
        wdata = {item.value, AW'(count)};
      end
      ST_SWAP_A: begin
        wen   = 1'b1;
        waddr = min_pos;
        wdata = first_entry;
      end
      ST_SWAP_B: begin
        wen   = 1'b1;
        waddr = pass;
        wdata = min_entry;
      end
      default: begin
        wen = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat.vld <= 1'b0;
    end else begin
      beat.vld <= (state == ST_SCAN);
    end
    beat.first <= (addr == pass);
    beat.pos   <= iss_pkg::INDEX_W'(addr);
  end

  iss_min_track #(
    .AW (AW)
  ) u_min_track (
    .clk         (clk),
    .beat        (beat),
    .rdata       (rdata),
    .min_entry   (min_entry),
    .min_pos     (min_pos),
    .first_entry (first_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      count    <= '0;
      ovf      <= 1'b0;
      last_pos <= '0;
      pass     <= '0;
      addr     <= '0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (item_acc) begin
            if (full) begin
              ovf <= 1'b1;
            end else begin
              count <= count + 1'b1;
            end
            if (item.last) begin
              last_pos <= last_pos_next;
              pass     <= '0;
              addr     <= '0;
              state    <= (last_pos_next == '0) ? ST_EMIT_RD : ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (addr == last_pos) begin
            state <= ST_DRAIN;
          end else begin
            addr <= addr + 1'b1;
          end
        end
        ST_DRAIN: begin
          state <= ST_SWAP_A;
        end
        ST_SWAP_A: begin
          state <= ST_SWAP_B;
        end
        ST_SWAP_B: begin
          if (pass_inc == last_pos) begin
            addr  <= '0;
            state <= ST_EMIT_RD;
          end else begin
            pass  <= pass_inc;
            addr  <= pass_inc;
            state <= ST_SCAN;
          end
        end
        ST_EMIT_RD: begin
          // output register is free at the next edge
          if (!result_valid || !result_stall) begin
            state <= ST_EMIT_LD;
          end
        end
        ST_EMIT_LD: begin
          if (addr == last_pos) begin
            count <= '0;
            ovf   <= 1'b0;
            state <= ST_LOAD;
          end else begin
            addr  <= addr + 1'b1;
            state <= ST_EMIT_RD;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == ST_EMIT_LD) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT_LD) begin
      result.sorted_value <= rdata[EW-1 -: iss_pkg::VALUE_W];
      result.source_index <= iss_pkg::INDEX_W'(rdata[AW-1:0]);
      result.end_of_run   <= (addr == last_pos);
      result.overflow     <= ovf;
    end
  end

endmodule

`default_nettype wire

// File: dv/indirect_selection_sort_tb.sv
// indirect_selection_sort_tb: self-checking bench for the indirect selection sorter
// drives sets of signed values, predicts the sorted order and arrival indexes, checks each item
// depends on iss_pkg and indirect_selection_sort from hdl
`timescale 1ns / 1ps

module indirect_selection_sort_tb;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 6;
  localparam int CAPACITY      = iss_pkg::MAX_ITEMS_DEF;
  localparam int RANDOM_ITEMS  = 130;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 150;

  typedef struct {
    logic signed [iss_pkg::VALUE_W-1:0] value;
    logic                               last;
    logic                               lone_value;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst;
  iss_pkg::in_item_t  item;
  logic               item_valid;
  logic               item_stall;
  iss_pkg::out_item_t result;
  logic               result_valid;
  logic               result_stall;

  // predictor state: values of the open set and the drop flag
  logic signed [iss_pkg::VALUE_W-1:0] open_set[$];
  logic                               dropped_in_set = 1'b0;
  iss_pkg::out_item_t                 sorted_expect_q[$];
  iss_pkg::out_item_t                 fresh_results[$];
  stim_row_t                          directed_rows[$];

  logic hold_request = 1'b0;
  int   fail_count = 0;
  int   items_accepted = 0;
  int   sets_closed = 0;
  int   overflow_sets = 0;
  int   results_checked = 0;
  int   idle_cycles = 0;

  indirect_selection_sort dut (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

  always #CLK_HALF clk = ~clk;

  // store one value, or flag it dropped when the set is full, and on the closing item sort the set by index permutation
  task automatic absorb_item(input iss_pkg::in_item_t it);
    logic [iss_pkg::INDEX_W-1:0] perm [CAPACITY];
    logic [iss_pkg::INDEX_W-1:0] min_idx;
    int                          n, p, i, min_pos;
    iss_pkg::out_item_t          r;
    if (open_set.size() < CAPACITY) open_set.push_back(it.value);
    else dropped_in_set = 1'b1;
    if (it.last) begin
      n = open_set.size();
      for (i = 0; i < n; i++) perm[i] = iss_pkg::INDEX_W'(i);
      for (p = 0; p + 1 < n; p++) begin
        min_pos = p;
        min_idx = perm[p];
        // first strictly smaller entry wins, which fixes the order of ties
        for (i = p + 1; i < n; i++) begin
          if (open_set[perm[i]] < open_set[min_idx]) begin
            min_idx = perm[i];
            min_pos = i;
          end
        end
        perm[min_pos] = perm[p];
        perm[p] = min_idx;
      end
      for (i = 0; i < n; i++) begin
        r.sorted_value = open_set[perm[i]];
        r.source_index = perm[i];
        r.end_of_run   = (i == n - 1);
        r.overflow     = dropped_in_set;
        fresh_results.push_back(r);
      end
      sets_closed++;
      if (dropped_in_set) overflow_sets++;
      open_set.delete();
      dropped_in_set = 1'b0;
    end
  endtask

  // lone_value: a one-value set whose result is known without sorting
  task automatic offer_item(input logic signed [iss_pkg::VALUE_W-1:0] v, input logic lst,
                            input logic lone_value);
    iss_pkg::in_item_t  tmp;
    iss_pkg::out_item_t want;
    tmp.value = v;
    tmp.last  = lst;
    item       <= tmp;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall !== 1'b0);
    items_accepted++;
    absorb_item(tmp);
    if (lone_value) begin
      want.sorted_value = v;
      want.source_index = '0;
      want.end_of_run   = 1'b1;
      want.overflow     = 1'b0;
      sorted_expect_q.push_back(want);
    end else begin
      foreach (fresh_results[i]) sorted_expect_q.push_back(fresh_results[i]);
    end
    fresh_results.delete();
  endtask

  task automatic pause_sender();
    int r, gap;
    r = $urandom_range(0, 99);
    if (r < 55) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (sorted_expect_q.size() != 0) @(posedge clk);
  endtask

  task automatic add_row(input logic signed [iss_pkg::VALUE_W-1:0] v, input logic lst,
                         input logic lone_value);
    stim_row_t row;
    row.value      = v;
    row.last       = lst;
    row.lone_value = lone_value;
    directed_rows.push_back(row);
  endtask

  function automatic logic signed [iss_pkg::VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      case ($urandom_range(0, 3))
        0:       return 32'sh8000_0000;
        1:       return 32'sh7fff_ffff;
        2:       return '0;
        default: return -1;
      endcase
    end
    // narrow range so ties show up often
    if (r < 40) return $signed(32'($urandom_range(0, 6))) - 3;
    return $urandom;
  endfunction

  // receiver: random stalls, calm stretches, and one long hold on request
  initial begin
    int r, stall_len, run_len;
    result_stall = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 20) begin
          stall_len = 0;
          run_len   = $urandom_range(20, 80);
        end else if (r < 28) begin
          stall_len = $urandom_range(20, 60);
          run_len   = $urandom_range(1, 4);
        end else begin
          stall_len = $urandom_range(1, 3);
          run_len   = $urandom_range(1, 6);
        end
        if (stall_len != 0) begin
          result_stall <= 1'b1;
          repeat (stall_len) @(posedge clk);
        end
        result_stall <= 1'b0;
        repeat (run_len) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_results
    iss_pkg::out_item_t want;
    if (!rst && result_valid === 1'b1 && result_stall === 1'b0) begin
      if (sorted_expect_q.size() == 0) begin
        $error("unexpected item: sorted_value %0d source_index %0d",
               result.sorted_value, result.source_index);
        fail_count++;
      end else begin
        want = sorted_expect_q.pop_front();
        results_checked++;
        if (result.sorted_value !== want.sorted_value) begin
          $error("sorted_value: expected %0d, got %0d", want.sorted_value, result.sorted_value);
          fail_count++;
        end
        if (result.source_index !== want.source_index) begin
          $error("source_index: expected %0d, got %0d", want.source_index, result.source_index);
          fail_count++;
        end
        if (result.end_of_run !== want.end_of_run) begin
          $error("end_of_run: expected %0b, got %0b", want.end_of_run, result.end_of_run);
          fail_count++;
        end
        if (result.overflow !== want.overflow) begin
          $error("overflow: expected %0b, got %0b", want.overflow, result.overflow);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if ((item_valid === 1'b1 && item_stall === 1'b0) ||
        (result_valid === 1'b1 && result_stall === 1'b0)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("indirect_selection_sort test failed");
        $finish;
      end
    end
  end

  initial begin
    int set_size, k, set_no, random_items;
    rst        = 1'b1;
    item       = '0;
    item_valid = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // one-value sets at the extremes, zero and minus one, then small sets with ties and reversals
    add_row(32'sh8000_0000, 1'b1, 1'b1);
    add_row(32'sh7fff_ffff, 1'b1, 1'b1);
    add_row(0,              1'b1, 1'b1);
    add_row(-1,             1'b1, 1'b1);
    add_row(5,  1'b0, 1'b0);
    add_row(0,  1'b0, 1'b0);
    add_row(-5, 1'b1, 1'b0);
    add_row(7,  1'b0, 1'b0);
    add_row(7,  1'b0, 1'b0);
    add_row(7,  1'b0, 1'b0);
    add_row(7,  1'b1, 1'b0);
    add_row(3,  1'b0, 1'b0);
    add_row(-1, 1'b0, 1'b0);
    add_row(3,  1'b0, 1'b0);
    add_row(-1, 1'b1, 1'b0);
    add_row(32'sh7fff_ffff, 1'b0, 1'b0);
    add_row(32'sh8000_0000, 1'b1, 1'b0);
    add_row(32'sh8000_0000, 1'b0, 1'b0);
    add_row(32'sh7fff_ffff, 1'b0, 1'b0);
    add_row(32'sh8000_0000, 1'b1, 1'b0);
    add_row(1, 1'b0, 1'b0);
    add_row(2, 1'b0, 1'b0);
    add_row(3, 1'b0, 1'b0);
    add_row(4, 1'b1, 1'b0);
    foreach (directed_rows[j]) begin
      offer_item(directed_rows[j].value, directed_rows[j].last, directed_rows[j].lone_value);
      pause_sender();
    end
    wait_for_drain();

    // long receiver hold while sets keep coming, so the input backs up
    hold_request = 1'b1;
    set_no       = 0;
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      if (set_no == 3) set_size = CAPACITY + $urandom_range(1, 3);
      else if ($urandom_range(0, 9) < 8) set_size = $urandom_range(1, 8);
      else set_size = $urandom_range(9, 24);
      for (k = 0; k < set_size; k++) begin
        offer_item(pick_value(), k == set_size - 1, 1'b0);
        pause_sender();
      end
      random_items += set_size;
      set_no++;
      if (set_no == 8) wait_for_drain();
    end

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("sorted %0d sets from %0d items (%0d over capacity), %0d results compared",
             sets_closed, items_accepted, overflow_sets, results_checked);
    if (fail_count == 0) begin
      $display("indirect_selection_sort test passed");
    end else begin
      $display("indirect_selection_sort test failed");
    end
    $finish;
  end

endmodule
